/* design/acc_pkg.sv */
// Shared types and constants for the box collision checker.
// Used by acc_front, acc_queue, acc_back and the top level.
package acc_pkg;

  localparam int MAX_BOXES_DEF  = 64;
  localparam int COORD_BITS_DEF = 24;
  localparam int RADIUS_BITS    = 16;
  localparam int CFG_IDX_BITS   = 3;

  typedef enum logic [2:0] {
    ACT_LOAD      = 3'd0,
    ACT_CLEAR     = 3'd1,
    ACT_POINT     = 3'd2,
    ACT_SEGMENT   = 3'd3,
    ACT_CLEARANCE = 3'd4
  } action_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_WS_MIN_X = 3'd0,
    CFG_WS_MIN_Y = 3'd1,
    CFG_WS_MIN_Z = 3'd2,
    CFG_WS_MAX_X = 3'd3,
    CFG_WS_MAX_Y = 3'd4,
    CFG_WS_MAX_Z = 3'd5,
    CFG_RADIUS   = 3'd6
  } cfg_idx_t;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_EMPTY_WS = 2'd2;

  typedef enum logic [2:0] {
    K_NOP,
    K_LOAD,
    K_CLEAR,
    K_POINT,
    K_SEGMENT,
    K_CLEARANCE
  } kind_t;

  typedef struct packed {
    kind_t kind;
    logic  empty;
    logic  a_out;
    logic  b_out;
  } cls_t;

  localparam int CLS_W = $bits(cls_t);

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_BOX,
    S_PREP,
    S_PROD,
    S_UPD,
    S_FIN1,
    S_FIN2
  } state_t;

endpackage

/* design/acc_front.sv */
// Front end: decodes the action and checks the workspace bounds.
// Depends on acc_pkg; feeds acc_queue.
module acc_front import acc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int ENTRY_W    = CLS_W + 6 * COORD_BITS + RADIUS_BITS
) (
  input  logic [2:0]                    action,
  input  logic signed [COORD_BITS-1:0]  a_x,
  input  logic signed [COORD_BITS-1:0]  a_y,
  input  logic signed [COORD_BITS-1:0]  a_z,
  input  logic signed [COORD_BITS-1:0]  b_x,
  input  logic signed [COORD_BITS-1:0]  b_y,
  input  logic signed [COORD_BITS-1:0]  b_z,
  input  logic [RADIUS_BITS-1:0]        extra_clearance,
  input  logic signed [COORD_BITS-1:0]  ws_min [3],
  input  logic signed [COORD_BITS-1:0]  ws_max [3],
  input  logic [RADIUS_BITS-1:0]        radius,
  output logic [ENTRY_W-1:0]            entry
);

  localparam int CB = COORD_BITS;
  localparam int GW = ((CB > RADIUS_BITS + 1) ? CB : RADIUS_BITS + 1) + 2;

  logic signed [GW-1:0] lo_lim [3];
  logic signed [GW-1:0] hi_lim [3];
  logic signed [GW-1:0] pa [3];
  logic signed [GW-1:0] pb [3];
  logic signed [GW-1:0] r_ext;
  cls_t                 cls;

  assign r_ext = $signed({{(GW-RADIUS_BITS){1'b0}}, radius});
  assign pa[0] = $signed({{(GW-CB){a_x[CB-1]}}, a_x});
  assign pa[1] = $signed({{(GW-CB){a_y[CB-1]}}, a_y});
  assign pa[2] = $signed({{(GW-CB){a_z[CB-1]}}, a_z});
  assign pb[0] = $signed({{(GW-CB){b_x[CB-1]}}, b_x});
  assign pb[1] = $signed({{(GW-CB){b_y[CB-1]}}, b_y});
  assign pb[2] = $signed({{(GW-CB){b_z[CB-1]}}, b_z});

  always_comb begin
    cls.empty = 1'b0;
    cls.a_out = 1'b0;
    cls.b_out = 1'b0;
    for (int k = 0; k < 3; k++) begin
      lo_lim[k] = $signed({{(GW-CB){ws_min[k][CB-1]}}, ws_min[k]}) + r_ext;
      hi_lim[k] = $signed({{(GW-CB){ws_max[k][CB-1]}}, ws_max[k]}) - r_ext;
      if (lo_lim[k] >= hi_lim[k]) cls.empty = 1'b1;
      if (pa[k] <= lo_lim[k] || pa[k] >= hi_lim[k]) cls.a_out = 1'b1;
      if (pb[k] <= lo_lim[k] || pb[k] >= hi_lim[k]) cls.b_out = 1'b1;
    end
    unique case (action)
      ACT_LOAD:      cls.kind = K_LOAD;
      ACT_CLEAR:     cls.kind = K_CLEAR;
      ACT_POINT:     cls.kind = K_POINT;
      ACT_SEGMENT:   cls.kind = K_SEGMENT;
      ACT_CLEARANCE: cls.kind = K_CLEARANCE;
      default:       cls.kind = K_NOP;
    endcase
  end

  assign entry = {extra_clearance, b_z, b_y, b_x, a_z, a_y, a_x, cls};

endmodule

/* design/acc_queue.sv */
// Two-entry queue between the front end and the back end.
// Depends on acc_pkg only for the default width CLS_W.
module acc_queue import acc_pkg::*; #(
  parameter int WIDTH = CLS_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_pop,
  output logic [WIDTH-1:0] out_data
);

  logic [WIDTH-1:0] slots [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       fill;
  logic             push;
  logic             pop;

  assign in_ready  = (fill != 2'd2);
  assign out_valid = (fill != 2'd0);
  assign out_data  = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_pop && out_valid;

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= in_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

/* design/acc_back.sv */
// Back end: box table, per-box slab test sequencer and result register.
// Depends on acc_pkg; fed by acc_queue.
module acc_back import acc_pkg::*; #(
  parameter int MAX_BOXES  = MAX_BOXES_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int ENTRY_W    = CLS_W + 6 * COORD_BITS + RADIUS_BITS,
  parameter int CNT_W      = $clog2(MAX_BOXES + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  input  logic [ENTRY_W-1:0]     q_data,
  output logic                   q_pop,
  input  logic [RADIUS_BITS-1:0] radius,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_blocked,
  output logic [1:0]             out_status,
  output logic [CNT_W-1:0]       out_count
);

  localparam int CB = COORD_BITS;
  localparam int RB = RADIUS_BITS;
  localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int GW = ((CB > RB + 1) ? CB : RB + 1) + 2;
  localparam int NW = GW + 2;
  localparam int PW = 2 * NW;
  localparam int BW = 6 * CB;

  state_t state;
  state_t state_next;

  logic [BW-1:0]          mem [MAX_BOXES];
  logic [BW-1:0]          rd_data;
  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       idx;
  logic                   pass;
  logic [1:0]             axis;
  logic                   rej;
  cls_t                   cmd;
  logic signed [CB-1:0]   ca [3];
  logic signed [CB-1:0]   cb [3];
  logic [RB-1:0]          cextra;
  logic signed [GW-1:0]   glo [3];
  logic signed [GW-1:0]   ghi [3];
  logic signed [NW-1:0]   pn1, pn2, pden;
  logic signed [NW-1:0]   en, ed, xn, xd;
  logic signed [PW-1:0]   p1, p2, p3, p4;

  cls_t                   hcls;
  logic [BW-1:0]          hbox;
  logic                   is_query;
  logic                   early_block;
  logic                   need_walk;
  logic [RB:0]            grow;
  logic signed [GW-1:0]   nlo [3];
  logic signed [GW-1:0]   nhi [3];
  logic                   in_a, in_b, inside_hit;
  logic                   last_box;
  logic signed [NW-1:0]   s_k, e_k, d_k, l_k, h_k, n1_k, n2_k, den_k;
  logic                   seg_hit;
  logic                   full;

  assign hcls = cls_t'(q_data[CLS_W-1:0]);
  assign hbox = q_data[CLS_W +: BW];
  assign q_pop = (state == S_IDLE) && q_valid && (!out_valid || out_ready);
  assign full = (count == CNT_W'(MAX_BOXES));
  assign is_query = (hcls.kind == K_POINT) || (hcls.kind == K_SEGMENT) ||
                    (hcls.kind == K_CLEARANCE);
  assign early_block = hcls.empty || hcls.a_out || (hcls.kind != K_POINT && hcls.b_out);
  assign need_walk = is_query && !early_block && (count != '0);
  assign grow = pass ? ({1'b0, radius} + {1'b0, cextra}) : {1'b0, radius};
  assign last_box = (idx + 1'b1 == count);

  always_comb begin
    in_a = 1'b1;
    in_b = 1'b1;
    for (int k = 0; k < 3; k++) begin
      nlo[k] = $signed({{(GW-CB){rd_data[k*CB+CB-1]}}, rd_data[k*CB +: CB]})
               - $signed({{(GW-RB-1){1'b0}}, grow});
      nhi[k] = $signed({{(GW-CB){rd_data[(k+3)*CB+CB-1]}}, rd_data[(k+3)*CB +: CB]})
               + $signed({{(GW-RB-1){1'b0}}, grow});
      if ($signed({{(GW-CB){ca[k][CB-1]}}, ca[k]}) < nlo[k] ||
          $signed({{(GW-CB){ca[k][CB-1]}}, ca[k]}) > nhi[k]) in_a = 1'b0;
      if ($signed({{(GW-CB){cb[k][CB-1]}}, cb[k]}) < nlo[k] ||
          $signed({{(GW-CB){cb[k][CB-1]}}, cb[k]}) > nhi[k]) in_b = 1'b0;
    end
    inside_hit = !pass && (in_a || (cmd.kind != K_POINT && in_b));
  end

  always_comb begin
    s_k  = $signed({{(NW-CB){ca[axis][CB-1]}}, ca[axis]});
    e_k  = $signed({{(NW-CB){cb[axis][CB-1]}}, cb[axis]});
    d_k  = e_k - s_k;
    l_k  = $signed({{(NW-GW){glo[axis][GW-1]}}, glo[axis]}) - s_k;
    h_k  = $signed({{(NW-GW){ghi[axis][GW-1]}}, ghi[axis]}) - s_k;
    den_k = d_k;
    n1_k = l_k;
    n2_k = h_k;
    if (d_k < 0) begin
      n1_k  = -l_k;
      n2_k  = -h_k;
      den_k = -d_k;
    end
    if (n1_k > n2_k) begin
      n1_k = n2_k;
      n2_k = (d_k < 0) ? -l_k : l_k;
    end
  end

  assign seg_hit = !rej && !(p1 > p2);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (q_pop && need_walk) state_next = S_READ;
      S_READ: state_next = S_BOX;
      S_BOX: begin
        if (inside_hit) state_next = S_IDLE;
        else if (cmd.kind == K_POINT) state_next = last_box ? S_IDLE : S_READ;
        else state_next = S_PREP;
      end
      S_PREP: begin
        if (d_k == 0) state_next = (axis == 2'd2) ? S_FIN1 : S_PREP;
        else state_next = S_PROD;
      end
      S_PROD: state_next = S_UPD;
      S_UPD:  state_next = (axis == 2'd2) ? S_FIN1 : S_PREP;
      S_FIN1: state_next = S_FIN2;
      S_FIN2: begin
        if (seg_hit) state_next = S_IDLE;
        else if (!last_box) state_next = S_READ;
        else if (!pass && cmd.kind == K_CLEARANCE) state_next = S_READ;
        else state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop && hcls.kind == K_LOAD && !full) mem[count[AW-1:0]] <= hbox;
    rd_data <= mem[idx[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_pop) begin
            if (hcls.kind == K_LOAD && !full) count <= count + 1'b1;
            if (hcls.kind == K_CLEAR) count <= '0;
            if (!need_walk) out_valid <= 1'b1;
          end
        end
        S_BOX: begin
          if (inside_hit || (cmd.kind == K_POINT && last_box)) out_valid <= 1'b1;
        end
        S_FIN2: begin
          if (seg_hit || (last_box && !(!pass && cmd.kind == K_CLEARANCE)))
            out_valid <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (q_pop) begin
          cmd   <= hcls;
          ca[0] <= hbox[0*CB +: CB];
          ca[1] <= hbox[1*CB +: CB];
          ca[2] <= hbox[2*CB +: CB];
          cb[0] <= hbox[3*CB +: CB];
          cb[1] <= hbox[4*CB +: CB];
          cb[2] <= hbox[5*CB +: CB];
          cextra <= q_data[CLS_W+BW +: RB];
          idx   <= '0;
          pass  <= 1'b0;
          out_blocked <= is_query && early_block;
          out_status  <= (is_query && hcls.empty) ? ST_EMPTY_WS :
                         (hcls.kind == K_LOAD && full) ? ST_FULL : ST_OK;
          out_count   <= (hcls.kind == K_CLEAR) ? '0 :
                         (hcls.kind == K_LOAD && !full) ? count + 1'b1 : count;
        end
      end
      S_BOX: begin
        for (int k = 0; k < 3; k++) begin
          glo[k] <= nlo[k];
          ghi[k] <= nhi[k];
        end
        axis <= 2'd0;
        rej  <= 1'b0;
        en   <= '0;
        ed   <= NW'(1);
        xn   <= NW'(1);
        xd   <= NW'(1);
        out_blocked <= inside_hit;
        out_status  <= ST_OK;
        out_count   <= count;
        if (!inside_hit && cmd.kind == K_POINT) idx <= idx + 1'b1;
      end
      S_PREP: begin
        pn1  <= n1_k;
        pn2  <= n2_k;
        pden <= den_k;
        if (d_k == 0) begin
          if (s_k < l_k + s_k || s_k > h_k + s_k) rej <= 1'b1;
          axis <= axis + 1'b1;
        end
      end
      S_PROD: begin
        p1 <= pn1 * ed;
        p2 <= en * pden;
        p3 <= xn * pden;
        p4 <= pn2 * xd;
      end
      S_UPD: begin
        if (p1 > p2) begin
          en <= pn1;
          ed <= pden;
        end
        if (p3 > p4) begin
          xn <= pn2;
          xd <= pden;
        end
        axis <= axis + 1'b1;
      end
      S_FIN1: begin
        p1 <= en * xd;
        p2 <= xn * ed;
      end
      S_FIN2: begin
        out_blocked <= seg_hit;
        out_status  <= ST_OK;
        out_count   <= count;
        if (last_box) begin
          idx  <= '0;
          pass <= 1'b1;
        end else begin
          idx <= idx + 1'b1;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_BOXES)) else $error("box count beyond table size");
  a_walk_index: assert property (@(posedge clk) disable iff (rst)
    (state == S_BOX) |-> (idx < count)) else $error("walk past stored boxes");
  a_busy_no_result: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !out_valid) else $error("result pending during walk");
`endif

endmodule

/* design/aabb_collision_checker_unit.sv */
// Obstacle box collision checker: config registers, front end, queue, back end.
// Depends on acc_pkg, acc_front, acc_queue and acc_back.
//
// Input channel s_axis: tuser carries the action (load box, clear table,
// point, segment or clearance query); tdata carries both corners and the
// extra clearance. Output channel m_axis returns one item per input item.
// The user must write the registers through cfg_we/cfg_index/cfg_data
// only while idle; the block itself does not enforce this. Table actions,
// empty-workspace answers and endpoints outside the shrunk workspace get
// a result without a table walk. A point query tests each stored box in
// turn. A segment query reads and tests each box, then takes a slab step
// per axis and two finishing steps; a clearance query may walk the table
// twice. The back end has a single multiply/compare sequencer over the table.
// A two-entry queue lets the input side take items while a query runs.
// Reset empties the box table, restores the full workspace and a zero
// radius. When m_axis_tready is low the result holds in the output
// register and the back end waits before starting the next item.
module aabb_collision_checker_unit import acc_pkg::*; #(
  parameter int MAX_BOXES  = MAX_BOXES_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int IN_W  = ((6 * COORD_BITS + RADIUS_BITS + 7) / 8) * 8,
  parameter int CNT_W = $clog2(MAX_BOXES + 1),
  parameter int OUT_W = ((3 + CNT_W + 7) / 8) * 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, extra_clearance
  input  logic [IN_W-1:0]         s_axis_tdata,
  // action
  input  logic [2:0]              s_axis_tuser,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // blocked, status, stored_boxes
  output logic [OUT_W-1:0]        m_axis_tdata,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [COORD_BITS-1:0]   cfg_data
);

  localparam int CB = COORD_BITS;
  localparam int ENTRY_W = CLS_W + 6 * CB + RADIUS_BITS;

  logic signed [CB-1:0]   ws_min [3];
  logic signed [CB-1:0]   ws_max [3];
  logic [RADIUS_BITS-1:0] radius;
  logic [ENTRY_W-1:0]     entry;
  logic [ENTRY_W-1:0]     q_data;
  logic                   q_valid;
  logic                   q_pop;
  logic                   out_blocked;
  logic [1:0]             out_status;
  logic [CNT_W-1:0]       out_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 3; k++) begin
        ws_min[k] <= $signed({1'b1, {(CB-1){1'b0}}});
        ws_max[k] <= $signed({1'b0, {(CB-1){1'b1}}});
      end
      radius <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WS_MIN_X: ws_min[0] <= cfg_data;
        CFG_WS_MIN_Y: ws_min[1] <= cfg_data;
        CFG_WS_MIN_Z: ws_min[2] <= cfg_data;
        CFG_WS_MAX_X: ws_max[0] <= cfg_data;
        CFG_WS_MAX_Y: ws_max[1] <= cfg_data;
        CFG_WS_MAX_Z: ws_max[2] <= cfg_data;
        CFG_RADIUS:   radius    <= cfg_data[RADIUS_BITS-1:0];
        default: ;
      endcase
    end
  end

  acc_front #(.COORD_BITS(CB), .ENTRY_W(ENTRY_W)) u_front (
    .action          (s_axis_tuser),
    .a_x             (s_axis_tdata[0*CB +: CB]),
    .a_y             (s_axis_tdata[1*CB +: CB]),
    .a_z             (s_axis_tdata[2*CB +: CB]),
    .b_x             (s_axis_tdata[3*CB +: CB]),
    .b_y             (s_axis_tdata[4*CB +: CB]),
    .b_z             (s_axis_tdata[5*CB +: CB]),
    .extra_clearance (s_axis_tdata[6*CB +: RADIUS_BITS]),
    .ws_min          (ws_min),
    .ws_max          (ws_max),
    .radius          (radius),
    .entry           (entry)
  );

  acc_queue #(.WIDTH(ENTRY_W)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (entry),
    .out_valid (q_valid),
    .out_pop   (q_pop),
    .out_data  (q_data)
  );

  acc_back #(
    .MAX_BOXES  (MAX_BOXES),
    .COORD_BITS (CB),
    .ENTRY_W    (ENTRY_W),
    .CNT_W      (CNT_W)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_data      (q_data),
    .q_pop       (q_pop),
    .radius      (radius),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_blocked (out_blocked),
    .out_status  (out_status),
    .out_count   (out_count)
  );

  assign m_axis_tdata = {{(OUT_W-3-CNT_W){1'b0}}, out_count, out_status, out_blocked};

endmodule

/* test/tb_aabb_collision_checker_unit.sv */
// Testbench for aabb_collision_checker_unit: directed and random items checked
// against an in-bench predictor of the box table and the collision tests.
// Depends on acc_pkg and the design files under design/.
module tb_aabb_collision_checker_unit;
  import acc_pkg::*;

  localparam int NBOX      = 64;
  localparam int IDLE_LIM  = 40000;
  localparam int SETTLE    = 40;
  localparam longint CMIN  = -8388608;
  localparam longint CMAX  = 8388607;

  typedef struct packed {
    logic [6:0] stored;
    logic [1:0] status;
    logic       blocked;
  } verdict_t;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [159:0] s_axis_tdata;
  logic [2:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [15:0]  m_axis_tdata;
  logic         cfg_we;
  logic [2:0]   cfg_index;
  logic [23:0]  cfg_data;

  aabb_collision_checker_unit dut (.*);

  // predictor state
  longint   box_lo[NBOX][3];
  longint   box_hi[NBOX][3];
  int       box_cnt;
  longint   ws_lo[3];
  longint   ws_hi[3];
  longint   radius;

  verdict_t verdict_q[$];
  int       errors;
  int       send_idle_pct;
  int       rx_stall_pct;
  int       hold_left;
  int       quiet_cycles;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // receiver: random stalls, or a long hold-off when asked
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    verdict_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[9:0];
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected item, expected none, actual %h", $time, got);
        errors++;
      end else begin
        want = verdict_q.pop_front();
        if (got.blocked !== want.blocked) begin
          $display("%0t: blocked expected %0d actual %0d", $time, want.blocked, got.blocked);
          errors++;
        end
        if (got.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
          errors++;
        end
        if (got.stored !== want.stored) begin
          $display("%0t: stored_boxes expected %0d actual %0d", $time, want.stored, got.stored);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIM) begin
      $display("aabb_collision_checker_unit verification failed");
      $finish;
    end
  end

  function automatic bit frac_gt(longint n1, longint d1, longint n2, longint d2);
    return n1 * d2 > n2 * d1;
  endfunction

  function automatic bit slab_hit(longint s[3], longint e[3], longint lo[3], longint hi[3]);
    longint en = 0, ed = 1, xn = 1, xd = 1;
    longint d, n1, n2, den, t;
    for (int k = 0; k < 3; k++) begin
      d = e[k] - s[k];
      if (d == 0) begin
        if (s[k] < lo[k] || s[k] > hi[k]) return 1'b0;
        continue;
      end
      n1 = lo[k] - s[k];
      n2 = hi[k] - s[k];
      den = d;
      if (d < 0) begin
        n1 = -n1; n2 = -n2; den = -d;
      end
      if (n1 > n2) begin
        t = n1; n1 = n2; n2 = t;
      end
      if (frac_gt(n1, den, en, ed)) begin
        en = n1; ed = den;
      end
      if (frac_gt(xn, xd, n2, den)) begin
        xn = n2; xd = den;
      end
      if (frac_gt(en, ed, xn, xd)) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic bit point_blocked(longint p[3]);
    bit in_box;
    for (int k = 0; k < 3; k++)
      if (p[k] <= ws_lo[k] + radius || p[k] >= ws_hi[k] - radius) return 1'b1;
    for (int i = 0; i < box_cnt; i++) begin
      in_box = 1'b1;
      for (int k = 0; k < 3; k++)
        if (p[k] < box_lo[i][k] - radius || p[k] > box_hi[i][k] + radius) in_box = 1'b0;
      if (in_box) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit segment_hits_any(longint s[3], longint e[3], longint grow);
    longint lo[3], hi[3];
    for (int i = 0; i < box_cnt; i++) begin
      for (int k = 0; k < 3; k++) begin
        lo[k] = box_lo[i][k] - grow;
        hi[k] = box_hi[i][k] + grow;
      end
      if (slab_hit(s, e, lo, hi)) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic verdict_t predict_verdict(logic [2:0] act, longint a[3], longint b[3],
                                               longint extra);
    verdict_t v;
    bit empty_ws, hit;
    v = '0;
    if (act == ACT_LOAD) begin
      if (box_cnt >= NBOX) begin
        v.status = ST_FULL;
      end else begin
        box_lo[box_cnt] = a;
        box_hi[box_cnt] = b;
        box_cnt++;
      end
    end else if (act == ACT_CLEAR) begin
      box_cnt = 0;
    end else if (act <= ACT_CLEARANCE) begin
      empty_ws = 1'b0;
      for (int k = 0; k < 3; k++)
        if (ws_lo[k] + radius >= ws_hi[k] - radius) empty_ws = 1'b1;
      if (empty_ws) begin
        v.blocked = 1'b1;
        v.status = ST_EMPTY_WS;
      end else if (act == ACT_POINT) begin
        v.blocked = point_blocked(a);
      end else begin
        hit = point_blocked(a) || point_blocked(b) || segment_hits_any(a, b, radius);
        if (!hit && act == ACT_CLEARANCE) hit = segment_hits_any(a, b, radius + extra);
        v.blocked = hit;
      end
    end
    v.stored = box_cnt[6:0];
    return v;
  endfunction

  task automatic send_item(logic [2:0] act, longint a[3], longint b[3], longint extra);
    verdict_t v;
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {extra[15:0], b[2][23:0], b[1][23:0], b[0][23:0],
                      a[2][23:0], a[1][23:0], a[0][23:0]};
    do @(posedge clk); while (!s_axis_tready);
    v = predict_verdict(act, a, b, extra);
    verdict_q = {verdict_q, v};
  endtask

  task automatic send_xyz(logic [2:0] act, longint ax, longint ay, longint az,
                          longint bx, longint by, longint bz, longint extra);
    longint a[3], b[3];
    a = '{ax, ay, az};
    b = '{bx, by, bz};
    send_item(act, a, b, extra);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, longint value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[23:0];
    @(posedge clk);
    if (idx <= CFG_WS_MIN_Z)
      ws_lo[idx] = longint'($signed(value[23:0]));
    else if (idx <= CFG_WS_MAX_Z)
      ws_hi[idx - CFG_WS_MAX_X] = longint'($signed(value[23:0]));
    else
      radius = value[15:0];
  endtask

  task automatic set_workspace(longint lo, longint hi, longint r);
    wait_idle();
    write_reg(CFG_WS_MIN_X, lo);
    write_reg(CFG_WS_MIN_Y, lo);
    write_reg(CFG_WS_MIN_Z, lo);
    write_reg(CFG_WS_MAX_X, hi);
    write_reg(CFG_WS_MAX_Y, hi);
    write_reg(CFG_WS_MAX_Z, hi);
    write_reg(CFG_RADIUS, r);
    cfg_we <= 1'b0;
  endtask

  function automatic longint rand_coord();
    if ($urandom_range(99) < 12) return longint'($signed(24'($urandom)));
    return longint'($urandom_range(6000)) - 3000;
  endfunction

  task automatic test_directed();
    send_xyz(ACT_POINT, 0, 0, 0, 0, 0, 0, 0);
    send_xyz(ACT_POINT, CMIN, 0, 0, 0, 0, 0, 0);
    send_xyz(ACT_POINT, 0, 0, CMAX, 0, 0, 0, 0);
    send_xyz(ACT_LOAD, -100, -100, -100, 100, 100, 100, 0);
    send_xyz(ACT_LOAD, 500, 0, 0, 400, 10, 10, 0);
    send_xyz(ACT_POINT, 0, 0, 0, 0, 0, 0, 0);
    send_xyz(ACT_POINT, 100, 100, 100, 0, 0, 0, 0);
    send_xyz(ACT_POINT, 101, 0, 0, 0, 0, 0, 0);
    send_xyz(ACT_SEGMENT, -1000, 0, 0, 1000, 0, 0, 0);
    send_xyz(ACT_SEGMENT, -1000, 200, 0, 1000, 200, 0, 0);
    send_xyz(ACT_SEGMENT, 300, 300, 300, 300, 300, 300, 0);
    send_xyz(ACT_SEGMENT, 300, 5, 5, 600, 5, 5, 0);
    send_xyz(ACT_SEGMENT, 450, -50, 5, 450, 50, 5, 0);
    send_xyz(ACT_SEGMENT, 200, 200, 200, -200, -200, -200, 0);
    send_xyz(ACT_CLEARANCE, -1000, 150, 0, 1000, 150, 0, 0);
    send_xyz(ACT_CLEARANCE, -1000, 150, 0, 1000, 150, 0, 50);
    send_xyz(ACT_CLEARANCE, 3000, 3000, 3000, 4000, -4000, 3000, 65535);
    send_xyz(3'(ACT_CLEARANCE) + 3'd1, 1, 2, 3, 4, 5, 6, 7);
    send_xyz(3'(ACT_CLEARANCE) + 3'd2, 0, 0, 0, 0, 0, 0, 0);
    send_xyz(3'(ACT_CLEARANCE) + 3'd3, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, 65535);
    send_xyz(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0);
    send_xyz(ACT_LOAD, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 65535);
    send_xyz(ACT_POINT, 7, -7, 7, 0, 0, 0, 0);
    send_xyz(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0);
  endtask

  task automatic test_config_extremes();
    set_workspace(-5000, 5000, 100);
    send_xyz(ACT_LOAD, -10, -10, -10, 10, 10, 10, 0);
    send_xyz(ACT_POINT, 110, 0, 0, 0, 0, 0, 0);
    send_xyz(ACT_POINT, 4900, 0, 0, 0, 0, 0, 0);
    send_xyz(ACT_SEGMENT, -3000, 111, 0, 3000, 111, 0, 0);
    set_workspace(CMIN, CMAX, 65535);
    send_xyz(ACT_POINT, 65546, 0, 0, 0, 0, 0, 0);
    send_xyz(ACT_CLEARANCE, 200000, 200000, 0, -200000, 200000, 0, 65535);
    set_workspace(0, 0, 0);
    send_xyz(ACT_POINT, 0, 0, 0, 0, 0, 0, 0);
    send_xyz(ACT_SEGMENT, 0, 0, 0, 1, 1, 1, 0);
    send_xyz(ACT_LOAD, 1, 1, 1, 2, 2, 2, 0);
    set_workspace(CMAX, CMIN, 0);
    send_xyz(ACT_CLEARANCE, 0, 0, 0, 1, 1, 1, 1);
    set_workspace(-1000, 1000, 999);
    send_xyz(ACT_POINT, 0, 0, 0, 0, 0, 0, 0);
    set_workspace(-1000, 1000, 1000);
    send_xyz(ACT_POINT, 0, 0, 0, 0, 0, 0, 0);
    send_xyz(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0);
  endtask

  task automatic test_table_full();
    longint c;
    set_workspace(-20000, 20000, 5);
    send_xyz(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0);
    for (int i = 0; i < NBOX + 2; i++) begin
      c = 300 * i - 9000;
      send_xyz(ACT_LOAD, c, c, 5000, c + 100, c + 100, 5100, 0);
    end
    send_xyz(ACT_POINT, 0, 0, 0, 0, 0, 0, 0);
    send_xyz(ACT_POINT, -8950, -8950, 5050, 0, 0, 0, 0);
    send_xyz(ACT_CLEARANCE, -10000, -10000, 4800, 10000, 10000, 4800, 200);
    send_xyz(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0);
  endtask

  task automatic run_random(int count);
    longint a[3], b[3], extra, t;
    logic [2:0] act;
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      for (int k = 0; k < 3; k++) begin
        a[k] = rand_coord();
        b[k] = rand_coord();
      end
      extra = ($urandom_range(3) == 0) ? longint'($urandom_range(65535))
                                       : longint'($urandom_range(400));
      if (pick < 25) begin
        act = ACT_LOAD;
        for (int k = 0; k < 3; k++) begin
          if (a[k] > b[k] && $urandom_range(9) != 0) begin
            t = a[k]; a[k] = b[k]; b[k] = t;
          end
          if (b[k] - a[k] > 1500 && $urandom_range(3) != 0) b[k] = a[k] + $urandom_range(800);
        end
      end else if (pick < 31 || (box_cnt > 20 && pick < 45)) begin
        act = ACT_CLEAR;
      end else if (pick < 50) begin
        act = ACT_POINT;
      end else if (pick < 95) begin
        act = (pick < 72) ? ACT_SEGMENT : ACT_CLEARANCE;
        for (int k = 0; k < 3; k++)
          if ($urandom_range(4) == 0) b[k] = a[k];
      end else begin
        act = 3'(ACT_CLEARANCE) + 3'($urandom_range(1, 3));
      end
      send_item(act, a, b, extra);
    end
  endtask

  task automatic test_random_phases();
    set_workspace(-3000, 3000, 40);
    send_idle_pct = 0;  rx_stall_pct = 0;  run_random(250);
    set_workspace(-2500, 2800, 0);
    send_idle_pct = 60; rx_stall_pct = 0;  run_random(250);
    set_workspace(CMIN, CMAX, 150);
    send_idle_pct = 0;  rx_stall_pct = 60; run_random(250);
    set_workspace(-3500, 3200, 300);
    send_idle_pct = 8;  rx_stall_pct = 8;  run_random(300);
  endtask

  task automatic test_backpressure();
    set_workspace(-3000, 3000, 20);
    send_idle_pct = 0;
    rx_stall_pct = 0;
    hold_left = 400;
    run_random(40);
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    errors = 0;
    send_idle_pct = 0;
    rx_stall_pct = 0;
    hold_left = 0;
    quiet_cycles = 0;
    box_cnt = 0;
    radius = 0;
    for (int k = 0; k < 3; k++) begin
      ws_lo[k] = CMIN;
      ws_hi[k] = CMAX;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_config_extremes();
    test_table_full();
    test_random_phases();
    test_backpressure();

    wait_idle();
    if (errors == 0)
      $display("aabb_collision_checker_unit verification clean");
    else
      $display("aabb_collision_checker_unit verification failed");
    $finish;
  end

endmodule
